@@ rtl/core/rgbhsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and constants of the HSL scale adjust pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_HUE   = 2'd0;
   localparam logic [1:0] REG_SAT   = 2'd1;
   localparam logic [1:0] REG_LIGHT = 2'd2;

   localparam logic [15:0] FACTOR_ONE = 16'd4096;

   localparam int DIV_NUM_W  = 28;
   localparam int DIV_DEN_W  = 12;
   localparam int DIV_QUO_W  = 18;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = DIV_QUO_W / DIV_STEPS;

   localparam logic [17:0] HUE_SIXTH      = 18'd32768;
   localparam logic [17:0] HUE_THIRD      = 18'd65536;
   localparam logic [17:0] HUE_HALF       = 18'd98304;
   localparam logic [17:0] HUE_TWO_THIRDS = 18'd131072;

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] light;
   } cfg_type;

   typedef enum logic [1:0] {
      SEL_RAMP,
      SEL_Q,
      SEL_P
   } chan_sel_type;

   typedef struct packed {
      chan_sel_type sel;
      logic [15:0]  x;
      logic [15:0]  p;
      logic [16:0]  q;
   } chan_req_type;

endpackage

@@ rtl/core/rgbhsl_csr.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_csr
// Register file for the hue, saturation and lightness factors.
// ----------------------------------------------------------------------------
module rgbhsl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rgbhsl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rgbhsl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rgbhsl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready,
   output rgbhsl_pkg::cfg_type               cfg
);

   rgbhsl_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]          idx;

   assign idx    = paddr[3:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            rgbhsl_pkg::REG_HUE:   cfg_in.hue   = pwdata[15:0];
            rgbhsl_pkg::REG_SAT:   cfg_in.sat   = pwdata[15:0];
            rgbhsl_pkg::REG_LIGHT: cfg_in.light = pwdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         rgbhsl_pkg::REG_HUE:   prdata = {16'd0, cfg_ff.hue};
         rgbhsl_pkg::REG_SAT:   prdata = {16'd0, cfg_ff.sat};
         rgbhsl_pkg::REG_LIGHT: prdata = {16'd0, cfg_ff.light};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue   <= rgbhsl_pkg::FACTOR_ONE;
         cfg_ff.sat   <= rgbhsl_pkg::FACTOR_ONE;
         cfg_ff.light <= rgbhsl_pkg::FACTOR_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/rgbhsl_div.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, three quotient bits per stage.
// ----------------------------------------------------------------------------
module rgbhsl_div (
   input  logic                             clock,
   input  logic [rgbhsl_pkg::DIV_NUM_W-1:0] num,
   input  logic [rgbhsl_pkg::DIV_DEN_W-1:0] den,
   output logic [rgbhsl_pkg::DIV_QUO_W-1:0] quo
);

   localparam int NW = rgbhsl_pkg::DIV_NUM_W;
   localparam int DW = rgbhsl_pkg::DIV_DEN_W;
   localparam int QW = rgbhsl_pkg::DIV_QUO_W;
   localparam int NS = rgbhsl_pkg::DIV_STAGES;

   logic [DW-1:0] rem_ff [NS-1];
   logic [QW-1:0] low_ff [NS-1];
   logic [DW-1:0] den_ff [NS-1];
   logic [QW-1:0] quo_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [DW-1:0] rem_cur, rem_in, den_cur;
      logic [QW-1:0] low_cur, low_in, quo_cur, quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = {{(DW - (NW - QW)){1'b0}}, num[NW-1:QW]};
         assign low_cur = num[QW-1:0];
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign low_cur = low_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      always_comb begin
         logic [DW:0] trial;
         rem_in = rem_cur;
         low_in = low_cur;
         quo_in = quo_cur;
         for (int i = 0; i < rgbhsl_pkg::DIV_STEPS; i++) begin
            trial  = {rem_in, low_in[QW-1]};
            low_in = {low_in[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_cur}) begin
               trial  = trial - {1'b0, den_cur};
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[k] <= quo_in;
      end

      if (k < NS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quo = quo_ff[NS-1];

endmodule

@@ rtl/core/rgbhsl_chan.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_chan
// Hue-to-channel ramp, clamp and byte rounding for one color channel.
// ----------------------------------------------------------------------------
module rgbhsl_chan (
   input  logic                     clock,
   input  rgbhsl_pkg::chan_req_type req,
   output logic [7:0]               chan_byte
);

   logic [32:0]              prod_ff, prod_in;
   rgbhsl_pkg::chan_sel_type sel_ff;
   logic [15:0]              p_ff;
   logic [16:0]              q_ff;
   logic [16:0]              v_ff, v_in;
   logic [7:0]               byte_ff, byte_in;

   logic [16:0] diff;
   logic [33:0] rnd;
   logic [18:0] vsum;
   logic [24:0] bsum;

   assign diff    = req.q - {1'b0, req.p};
   assign prod_in = {16'd0, diff} * {17'd0, req.x};

   always_comb begin
      rnd = {1'b0, prod_ff} + 34'd16384;
      case (sel_ff)
         rgbhsl_pkg::SEL_RAMP: vsum = {3'd0, p_ff} + rnd[33:15];
         rgbhsl_pkg::SEL_Q:    vsum = {2'd0, q_ff};
         default:              vsum = {3'd0, p_ff};
      endcase
      v_in = (vsum > 19'd65536) ? 17'h10000 : vsum[16:0];
   end

   always_comb begin
      bsum    = {v_ff, 8'd0} - {8'd0, v_ff} + 25'd32768;
      byte_in = bsum[23:16];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel_ff  <= req.sel;
      p_ff    <= req.p;
      q_ff    <= req.q;
      v_ff    <= v_in;
      byte_ff <= byte_in;
   end

   assign chan_byte = byte_ff;

endmodule

@@ rtl/core/rgb_hsl_scale_adjust.sv @@
// ----------------------------------------------------------------------------
// rgb_hsl_scale_adjust
// RGBA pixel to HSL, per-component scale and clamp, and back to RGB.
// ----------------------------------------------------------------------------
// The request passes a 14-stage pipeline, with two six-stage dividers
// for hue and saturation, to the result strobe.
// Throughput: one pixel per cycle; busy stays low.
// Reset clears the pipeline valid bits and sets every factor to 1.0.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module rgb_hsl_scale_adjust (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [7:0]                        req_red_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_blue_in,
   input  logic [7:0]                        req_alpha_in,
   output logic                              rsp_strobe,
   output logic [7:0]                        rsp_red_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_blue_out,
   output logic [7:0]                        rsp_alpha_out,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rgbhsl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rgbhsl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rgbhsl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);

   localparam int DEPTH = 14;
   localparam int DS    = rgbhsl_pkg::DIV_STAGES;

   function automatic logic [15:0] sat16(input logic [20:0] v);
      return (v > 21'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic rgbhsl_pkg::chan_req_type classify(input logic [17:0] t,
                                                         input logic [15:0] p,
                                                         input logic [16:0] q);
      rgbhsl_pkg::chan_req_type r;
      logic [17:0]              fall;
      fall = rgbhsl_pkg::HUE_TWO_THIRDS - t;
      r.p  = p;
      r.q  = q;
      r.x  = '0;
      if (t < rgbhsl_pkg::HUE_SIXTH) begin
         r.sel = rgbhsl_pkg::SEL_RAMP;
         r.x   = t[15:0];
      end else if (t < rgbhsl_pkg::HUE_HALF) begin
         r.sel = rgbhsl_pkg::SEL_Q;
      end else if (t < rgbhsl_pkg::HUE_TWO_THIRDS) begin
         r.sel = rgbhsl_pkg::SEL_RAMP;
         r.x   = fall[15:0];
      end else begin
         r.sel = rgbhsl_pkg::SEL_P;
      end
      return r;
   endfunction

   rgbhsl_pkg::cfg_type cfg;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [7:0]       alpha_ff [DEPTH];

   // front end
   logic [7:0]  mx, mn, d;
   logic [8:0]  sum, den;
   logic [10:0] n;
   logic [27:0] num_s_in, num_h_in, num_s_ff, num_h_ff;
   logic [11:0] den_s_in, den_h_in, den_s_ff, den_h_ff;
   logic [8:0]  sum_ff, sum1_ff;
   logic        grey_ff [DS+1];

   // lightness side path
   logic [32:0] lz_prod;
   logic [8:0]  lz_ff;
   logic [16:0] l_raw;
   logic [15:0] l2_ff;
   logic [15:0] l_dly_ff [DS-2];

   logic [17:0] quo_s, quo_h;

   // scale and back conversion
   logic [15:0] h_in7, s_in7;
   logic [31:0] hp_ff, sp_ff, lp_ff;
   logic [32:0] hr, sr, lr;
   logic [15:0] h8_ff, s8_ff, l8_ff;
   logic [31:0] lsp_ff;
   logic [15:0] h9_ff, s9_ff, l9_ff;
   logic [31:0] ls_sum;
   logic [15:0] ls;
   logic [16:0] q_val;
   logic [17:0] p_sgn;
   logic [15:0] p_val;
   logic [17:0] t0, t_red, t_blue;
   rgbhsl_pkg::chan_req_type chan_req_ff [3];
   rgbhsl_pkg::chan_req_type chan_req_in [3];
   logic [7:0]  chan_byte [3];

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[DEPTH-2:0], start & ~busy};

   rgbhsl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      mx = req_red_in;
      mn = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx)  mx = req_blue_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn)  mn = req_blue_in;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den = (sum > 9'd255) ? (9'd510 - sum) : sum;
      if (mx == req_red_in) begin
         n = {3'd0, req_green_in} - {3'd0, req_blue_in}
           + ((req_green_in < req_blue_in) ? ({3'd0, d} * 11'd6) : 11'd0);
      end else if (mx == req_green_in) begin
         n = {3'd0, req_blue_in} - {3'd0, req_red_in} + {2'd0, d, 1'b0};
      end else begin
         n = {3'd0, req_red_in} - {3'd0, req_green_in} + {1'b0, d, 2'b0};
      end
      num_s_in = {3'd0, d, 17'd0} + {19'd0, den};
      den_s_in = {2'd0, den, 1'b0};
      num_h_in = {n, 17'd0} + {17'd0, ({3'd0, d} * 11'd6)};
      den_h_in = {1'b0, d, 3'd0} + {2'd0, d, 2'd0};
   end

   always_ff @(posedge clock) begin
      num_s_ff    <= num_s_in;
      den_s_ff    <= den_s_in;
      num_h_ff    <= num_h_in;
      den_h_ff    <= den_h_in;
      sum_ff      <= sum;
      grey_ff[0]  <= (d == 8'd0);
      alpha_ff[0] <= req_alpha_in;
      for (int i = 1; i <= DS; i++) grey_ff[i] <= grey_ff[i-1];
      for (int i = 1; i < DEPTH; i++) alpha_ff[i] <= alpha_ff[i-1];
   end

   rgbhsl_div u_div_sat (
      .clock (clock),
      .num   (num_s_ff),
      .den   (den_s_ff),
      .quo   (quo_s)
   );

   rgbhsl_div u_div_hue (
      .clock (clock),
      .num   (num_h_ff),
      .den   (den_h_ff),
      .quo   (quo_h)
   );

   // lightness = sum*128 + (sum*128 + 127) / 255
   assign lz_prod = {17'd0, ({sum_ff, 7'd0} + 16'd127)} * {16'd0, 17'd65794};
   assign l_raw   = {1'b0, sum1_ff, 7'd0} + {8'd0, lz_ff};

   always_ff @(posedge clock) begin
      lz_ff       <= lz_prod[32:24];
      sum1_ff     <= sum_ff;
      l2_ff       <= sat16({4'd0, l_raw});
      l_dly_ff[0] <= l2_ff;
      for (int i = 1; i < DS - 2; i++) l_dly_ff[i] <= l_dly_ff[i-1];
   end

   assign h_in7 = grey_ff[DS] ? 16'd0 : sat16({3'd0, quo_h});
   assign s_in7 = grey_ff[DS] ? 16'd0 : sat16({3'd0, quo_s});

   assign hr = {1'b0, hp_ff} + 33'd2048;
   assign sr = {1'b0, sp_ff} + 33'd2048;
   assign lr = {1'b0, lp_ff} + 33'd2048;

   always_ff @(posedge clock) begin
      hp_ff  <= {16'd0, h_in7} * {16'd0, cfg.hue};
      sp_ff  <= {16'd0, s_in7} * {16'd0, cfg.sat};
      lp_ff  <= {16'd0, l_dly_ff[DS-3]} * {16'd0, cfg.light};
      h8_ff  <= sat16(hr[32:12]);
      s8_ff  <= sat16(sr[32:12]);
      l8_ff  <= sat16(lr[32:12]);
      lsp_ff <= {16'd0, l8_ff} * {16'd0, s8_ff};
      h9_ff  <= h8_ff;
      s9_ff  <= s8_ff;
      l9_ff  <= l8_ff;
   end

   always_comb begin
      ls_sum = lsp_ff + 32'd32768;
      ls     = ls_sum[31:16];
      if (l9_ff < 16'd32768) begin
         q_val = {1'b0, l9_ff} + {1'b0, ls};
      end else begin
         q_val = {1'b0, l9_ff} + {1'b0, s9_ff} - {1'b0, ls};
      end
      p_sgn = {1'b0, l9_ff, 1'b0} - {1'b0, q_val};
      p_val = p_sgn[17] ? 16'd0 : p_sgn[15:0];
      t0    = {1'b0, h9_ff, 1'b0} + {2'd0, h9_ff};
      t_red = (t0 > rgbhsl_pkg::HUE_TWO_THIRDS) ? (t0 - rgbhsl_pkg::HUE_TWO_THIRDS)
                                                : (t0 + rgbhsl_pkg::HUE_THIRD);
      t_blue = (t0 < rgbhsl_pkg::HUE_THIRD) ? (t0 + rgbhsl_pkg::HUE_TWO_THIRDS)
                                            : (t0 - rgbhsl_pkg::HUE_THIRD);
      chan_req_in[0] = classify(t_red, p_val, q_val);
      chan_req_in[1] = classify(t0, p_val, q_val);
      chan_req_in[2] = classify(t_blue, p_val, q_val);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) chan_req_ff[i] <= chan_req_in[i];
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      rgbhsl_chan u_chan (
         .clock     (clock),
         .req       (chan_req_ff[c]),
         .chan_byte (chan_byte[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_strobe    = vld_ff[DEPTH-1];
   assign rsp_red_out   = chan_byte[0];
   assign rsp_green_out = chan_byte[1];
   assign rsp_blue_out  = chan_byte[2];
   assign rsp_alpha_out = alpha_ff[DEPTH-1];

   // zero saturation collapses p and q onto lightness
   a_grey_pq : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[9] && s9_ff == 16'd0) |=>
      (chan_req_ff[1].q == {1'b0, chan_req_ff[1].p}))
      else $error("p and q differ with zero saturation");

   a_hue_write : assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr[3:2] == rgbhsl_pkg::REG_HUE) |=>
      (cfg.hue == $past(pwdata[15:0])))
      else $error("hue factor write lost");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives RGBA pixels through the HSL scale adjust block under several factor
// settings and checks every returned pixel against a fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct {
      pixel_type pix;
      bit        known;
      pixel_type want;
   } pixel_row_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [7:0]            req_red_in, req_green_in, req_blue_in, req_alpha_in;
   logic                              rsp_strobe;
   logic [7:0]            rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic                              psel, penable, pwrite;
   logic [rgbhsl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rgbhsl_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rgbhsl_pkg::CSR_DATA_W-1:0] prdata;
   logic                              pready;

   logic [15:0] hue_gain, sat_gain, light_gain;
   pixel_type   pending_pixels[$];
   int          error_count;
   int          pixel_count;
   int          setting_count;
   int          sender_idle_pct;

   rgb_hsl_scale_adjust u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_alpha_in(req_alpha_in),
      .rsp_strobe(rsp_strobe), .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out),
      .rsp_alpha_out(rsp_alpha_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint sat_q16(longint x);
      return (x > 65535) ? 65535 : x;
   endfunction

   function automatic longint apply_gain(longint x, logic [15:0] f);
      return sat_q16((x * longint'(f) + 2048) >>> 12);
   endfunction

   function automatic longint hue_ramp(longint p, longint q, longint t);
      if (t < 0) t += 196608;
      if (t > 196608) t -= 196608;
      if (t < 32768) return p + (((q - p) * t + 16384) >>> 15);
      if (t < 98304) return q;
      if (t < 131072) return p + (((q - p) * (131072 - t) + 16384) >>> 15);
      return p;
   endfunction

   function automatic logic [7:0] to_byte(longint v);
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      return 8'((v * 255 + 32768) >>> 16);
   endfunction

   function automatic pixel_type adjust_pixel(pixel_type px);
      longint r, g, b, mx, mn, d, den, n, h, s, l, ls, q, p, t;
      pixel_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      mn = r;
      h = 0;
      s = 0;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      l = sat_q16(((mx + mn) * 65536 + 255) / 510);
      if (mx != mn) begin
         d = mx - mn;
         den = (mx + mn > 255) ? (510 - mx - mn) : (mx + mn);
         s = sat_q16((d * 131072 + den) / (2 * den));
         if (mx == r) n = g - b + ((g < b) ? 6 * d : 0);
         else if (mx == g) n = b - r + 2 * d;
         else n = r - g + 4 * d;
         h = sat_q16((n * 131072 + 6 * d) / (12 * d));
      end
      h = apply_gain(h, hue_gain);
      s = apply_gain(s, sat_gain);
      l = apply_gain(l, light_gain);
      res.alpha = px.alpha;
      if (s == 0) begin
         res.red = to_byte(l);
         res.green = res.red;
         res.blue = res.red;
      end else begin
         ls = (l * s + 32768) >>> 16;
         q = (l < 32768) ? l + ls : l + s - ls;
         p = 2 * l - q;
         if (p < 0) p = 0;
         t = 3 * h;
         res.red = to_byte(hue_ramp(p, q, t + 65536));
         res.green = to_byte(hue_ramp(p, q, t));
         res.blue = to_byte(hue_ramp(p, q, t - 65536));
      end
      return res;
   endfunction

   task automatic write_gain(logic [1:0] idx, logic [15:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= rgbhsl_pkg::CSR_ADDR_W'({idx, 2'b00});
      pwdata <= {16'hdead, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         rgbhsl_pkg::REG_HUE: hue_gain = val;
         rgbhsl_pkg::REG_SAT: sat_gain = val;
         default: light_gain = val;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_gains(logic [15:0] hg, logic [15:0] sg, logic [15:0] lg);
      drain();
      write_gain(rgbhsl_pkg::REG_HUE, hg);
      write_gain(rgbhsl_pkg::REG_SAT, sg);
      write_gain(rgbhsl_pkg::REG_LIGHT, lg);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      setting_count++;
   endtask

   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_red_in <= px.red;
      req_green_in <= px.green;
      req_blue_in <= px.blue;
      req_alpha_in <= px.alpha;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_pixels.push_back(adjust_pixel(px));
      pixel_count++;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      px = $urandom;
      case ($urandom_range(5))
         0: px.green = px.red;
         1: px.blue = px.red;
         2: begin
            px.green = px.red;
            px.blue = px.red;
         end
         3: px.red = 8'hff;
         default: ;
      endcase
      return px;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel %h %h %h %h",
                   rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
            error_count++;
         end else begin
            pixel_type want;
            want = pending_pixels.pop_front();
            if (rsp_red_out !== want.red) begin
               $error("red_out expected %0d got %0d", want.red, rsp_red_out);
               error_count++;
            end
            if (rsp_green_out !== want.green) begin
               $error("green_out expected %0d got %0d", want.green, rsp_green_out);
               error_count++;
            end
            if (rsp_blue_out !== want.blue) begin
               $error("blue_out expected %0d got %0d", want.blue, rsp_blue_out);
               error_count++;
            end
            if (rsp_alpha_out !== want.alpha) begin
               $error("alpha_out expected %0d got %0d", want.alpha, rsp_alpha_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      pixel_row_type rows[$];
      pixel_type     got;
      logic [15:0]   gain_choices[6];
      error_count = 0;
      pixel_count = 0;
      setting_count = 0;
      sender_idle_pct = 0;
      hue_gain = rgbhsl_pkg::FACTOR_ONE;
      sat_gain = rgbhsl_pkg::FACTOR_ONE;
      light_gain = rgbhsl_pkg::FACTOR_ONE;
      reset = 1'b1;
      start = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_alpha_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{'{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff, 8'hff, 8'hff}},
         '{'{8'hff, 8'h00, 8'h00, 8'h5a}, 1'b1, '{8'hff, 8'h00, 8'h00, 8'h5a}},
         '{'{8'h00, 8'hff, 8'h00, 8'ha5}, 1'b1, '{8'h00, 8'hff, 8'h00, 8'ha5}},
         '{'{8'h00, 8'h00, 8'hff, 8'h01}, 1'b1, '{8'h00, 8'h00, 8'hff, 8'h01}},
         '{'{8'h80, 8'h80, 8'h80, 8'h80}, 1'b1, '{8'h80, 8'h80, 8'h80, 8'h80}},
         '{'{8'hff, 8'h00, 8'h01, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'hff, 8'hff, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'h00, 8'hff, 8'hff, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'hff, 8'h00, 8'hff, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'h01, 8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'hfe, 8'hff, 8'hff, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'h80, 8'h7f, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}},
         '{'{8'h12, 8'h9c, 8'h47, 8'h33}, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00}}
      };
      foreach (rows[i]) begin
         send_pixel(rows[i].pix);
         if (rows[i].known && pending_pixels[$] !== rows[i].want) begin
            got = pending_pixels[$];
            $error("table row %0d predictor expected %h got %h", i, rows[i].want, got);
            error_count++;
         end
      end

      // push hue past the circle, kill saturation, saturate lightness
      set_gains(16'hffff, 16'h0000, 16'hffff);
      foreach (rows[i]) send_pixel(rows[i].pix);
      set_gains(16'h0000, 16'hffff, 16'h0800);
      foreach (rows[i]) send_pixel(rows[i].pix);

      gain_choices = '{16'h0000, 16'h1000, 16'hffff, 16'h0800, 16'h1400, 16'h2000};
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
         for (int k = 0; k < 6; k++) begin
            if (k % 2 == 0)
               set_gains(gain_choices[$urandom_range(5)], gain_choices[$urandom_range(5)],
                         gain_choices[$urandom_range(5)]);
            else
               set_gains(16'($urandom), 16'($urandom_range(8192)), 16'($urandom_range(8192)));
            for (int j = 0; j < 100; j++) begin
               send_pixel(random_pixel());
               if (j == 50 && k == 2) begin
                  start <= 1'b0;
                  while (pending_pixels.size() != 0) @(posedge clock);
               end
            end
         end
      end
      set_gains(rgbhsl_pkg::FACTOR_ONE, rgbhsl_pkg::FACTOR_ONE, rgbhsl_pkg::FACTOR_ONE);

      $display("covered %0d pixels over %0d gain settings, incl. zero and full-scale gains",
               pixel_count, setting_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
